// File: src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

// File: src/cdq_pkg.sv
// ============================================================================
// Circular deque package
// Sizes, operation and status codes, word types and helpers of the deque.
// ============================================================================
package cdq_pkg;

   // Number of entries and bits kept per entry.
   localparam int DEPTH       = 8;
   localparam int VALUE_WIDTH = 32;

   // Operation codes.
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // Request word.
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] push_value;
   } cdq_req_type;

   // Result word.
   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic               now_empty;
      logic               now_full;
   } cdq_rsp_type;

   // Command broadcast to every cell; at most one flag is set.
   typedef struct packed {
      logic      push_front;
      logic      push_rear;
      logic      pop_front;
      logic      pop_rear;
      value_type value;
   } cdq_cmd_type;

   // Sign-extend a stored entry and keep the low 32 bits.
   function automatic logic [31:0] widen(input value_type v);
      logic signed [63:0] ext;
      ext = 64'(signed'(v));
      return ext[31:0];
   endfunction

endpackage

// File: src/cdq_cell.sv
// ============================================================================
// Deque cell
// One entry of the deque: a value and a valid bit, shifted between neighbors.
// ============================================================================
module cdq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  cdq_pkg::cdq_cmd_type cmd,
   input  cdq_pkg::value_type   left_value,
   input  logic                 left_valid,
   input  cdq_pkg::value_type   right_value,
   input  logic                 right_valid,
   output cdq_pkg::value_type   cell_value,
   output logic                 cell_valid,
   output logic                 valid_next
);
   import cdq_pkg::*;

   value_type value_ff;
   value_type value_in;
   logic      valid_ff;
   logic      valid_in;

   // Entries sit packed from cell 0 (front) toward the rear. A front push
   // shifts everything one cell toward the rear, a front pop one cell back.
   // The left neighbor of cell 0 presents the pushed value as valid.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.push_front) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (cmd.push_rear) begin
         // The first free cell takes the value.
         if (!valid_ff && left_valid) begin
            value_in = cmd.value;
            valid_in = 1'b1;
         end
      end else if (cmd.pop_front) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (cmd.pop_rear) begin
         // The last occupied cell lets go of its entry.
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   // The valid bit is control state; the value needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   assign cell_valid = valid_ff;
   assign valid_next = valid_in;

endmodule

// File: src/circular_deque_core.sv
`include "assert_macros.svh"
// ============================================================================
// Circular deque core
// Double-ended queue of DEPTH entries built as a row of shifting cells.
// ============================================================================
// Usage:
//   A request word is taken at a rising edge with start high and busy low.
//   Its operation is push front, push rear, pop front or pop rear. busy stays
//   low, so one word can be taken in every cycle.
//   Each request gives one result word on rsp_word, marked by rsp_strobe for
//   exactly one cycle, the cycle after the request was taken (throughput one
//   word per cycle). The result carries the popped value
//   (zero on pushes and refusals), the status and the empty and full flags
//   as they stand after the operation.
//   The cells update in the same edge that takes the request, so the row of
//   cells and the one result register set both latency and rate.
//   A push to a full deque or a pop from an empty one changes nothing.
//   Reset (synchronous, active high) empties the deque and drops any strobe.
//   The receiver cannot stall; it must take each result in its cycle.
// ============================================================================
module circular_deque_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cdq_pkg::cdq_req_type req_word,
   output logic                 rsp_strobe,
   output cdq_pkg::cdq_rsp_type rsp_word
);
   import cdq_pkg::*;

   logic        accept;
   logic        is_empty;
   logic        is_full;
   cdq_cmd_type cmd;
   logic [1:0]  status;
   logic        take_front;
   logic        take_rear;
   value_type   rear_value;
   logic [31:0] popped;

   value_type        cell_value [DEPTH];
   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH-1:0] valid_next;
   logic [DEPTH-1:0] tail_vec;
   logic [DEPTH-1:0] therm_probe;
   logic             rsp_refused;
   logic             flags_agree;

   logic        rsp_strobe_ff;
   cdq_rsp_type rsp_word_ff;
   cdq_rsp_type rsp_word_in;

   // The deque takes a word in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_empty = !valid_vec[0];
   assign is_full  = valid_vec[DEPTH-1];

   // Decode the operation and refuse it when it cannot be carried out.
   always_comb begin
      cmd        = '0;
      cmd.value  = value_type'(req_word.push_value);
      status     = ST_DONE;
      take_front = 1'b0;
      take_rear  = 1'b0;
      case (req_word.operation)
         OP_PUSH_FRONT: begin
            if (is_full) status = ST_FULL;
            else cmd.push_front = accept;
         end
         OP_PUSH_REAR: begin
            if (is_full) status = ST_FULL;
            else cmd.push_rear = accept;
         end
         OP_POP_FRONT: begin
            if (is_empty) status = ST_EMPTY;
            else begin
               cmd.pop_front = accept;
               take_front    = 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (is_empty) status = ST_EMPTY;
            else begin
               cmd.pop_rear = accept;
               take_rear    = 1'b1;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // Row of cells, front at cell 0.
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         value_type left_value;
         logic      left_valid;
         value_type right_value;
         logic      right_valid;

         if (gi == 0) begin : g_first
            assign left_value = cmd.value;
            assign left_valid = 1'b1;
         end else begin : g_inner_left
            assign left_value = cell_value[gi-1];
            assign left_valid = valid_vec[gi-1];
         end

         if (gi == DEPTH-1) begin : g_last
            assign right_value = '0;
            assign right_valid = 1'b0;
         end else begin : g_inner_right
            assign right_value = cell_value[gi+1];
            assign right_valid = valid_vec[gi+1];
         end

         assign tail_vec[gi] = valid_vec[gi] && !right_valid;

         cdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .cell_value  (cell_value[gi]),
            .cell_valid  (valid_vec[gi]),
            .valid_next  (valid_next[gi])
         );
      end
   endgenerate

   // The rear entry is the one occupied cell whose right neighbor is free.
   always_comb begin
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_value = rear_value | (tail_vec[i] ? cell_value[i] : '0);
      end
   end

   // Assemble the result word: popped value from the cells before the operation, flags after it.
   always_comb begin
      popped = '0;
      if (take_front) popped = widen(cell_value[0]);
      else if (take_rear) popped = widen(rear_value);
      rsp_word_in.popped_value = signed'(popped);
      rsp_word_in.status       = status;
      rsp_word_in.now_empty    = !valid_next[0];
      rsp_word_in.now_full     = valid_next[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Occupied cells always form one run starting at cell 0.
   assign therm_probe = valid_vec + DEPTH'(1);

   // A refused operation, and flags that agree with the cells.
   assign rsp_refused = rsp_strobe && rsp_word.status != ST_DONE;
   assign flags_agree = (rsp_word.now_empty == !valid_vec[0]) &&
                        (rsp_word.now_full == valid_vec[DEPTH-1]);

   `ASSERT_ALWAYS(a_cells_packed, (therm_probe & valid_vec) == '0)
   `ASSERT_IMPLIES(a_strobe_follows_accept, rsp_strobe, $past(accept))
   `ASSERT_IMPLIES(a_refusal_keeps_state, rsp_refused, valid_vec == $past(valid_vec))
   `ASSERT_ALWAYS(a_not_empty_and_full, !(rsp_strobe && rsp_word.now_empty && rsp_word.now_full))
   `ASSERT_IMPLIES(a_flags_match_cells, rsp_strobe, flags_agree)

endmodule

// File: tb/cdq_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Circular deque result checker
// Watches the request and result channels of the deque core, keeps its own
// copy of the ring and its pointers, and compares every result word with the
// word that the accepted request should have produced.
// ============================================================================
module cdq_result_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  cdq_pkg::cdq_req_type req_word,
   input  logic                 rsp_strobe,
   input  cdq_pkg::cdq_rsp_type rsp_word,
   output int                   error_count,
   output int                   pending_count
);
   import cdq_pkg::*;

   // Shadow copy of the deque state.
   value_type   shadow_ring [DEPTH];
   int          shadow_front;
   int          shadow_rear;
   logic        shadow_empty;

   // Results predicted for accepted request words, oldest first.
   cdq_rsp_type awaited_results [$];
   cdq_rsp_type want;

   function automatic int ring_next(input int idx);
      return (idx + 1 >= DEPTH) ? 0 : idx + 1;
   endfunction

   function automatic int ring_prev(input int idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
   endfunction

   function automatic logic shadow_full();
      return !shadow_empty && (ring_next(shadow_rear) == shadow_front);
   endfunction

   // Apply one request word to the shadow state and return the result word.
   function automatic cdq_rsp_type apply_deque_op(input cdq_req_type w);
      cdq_rsp_type r;
      int          slot;
      r        = '0;
      r.status = ST_DONE;
      if (w.operation == OP_PUSH_FRONT || w.operation == OP_PUSH_REAR) begin
         if (shadow_full()) begin
            r.status = ST_FULL;
         end else if (shadow_empty) begin
            // The first entry always lands in slot zero.
            shadow_front   = 0;
            shadow_rear    = 0;
            shadow_empty   = 1'b0;
            shadow_ring[0] = value_type'(w.push_value);
         end else if (w.operation == OP_PUSH_FRONT) begin
            shadow_front              = ring_prev(shadow_front);
            shadow_ring[shadow_front] = value_type'(w.push_value);
         end else begin
            shadow_rear              = ring_next(shadow_rear);
            shadow_ring[shadow_rear] = value_type'(w.push_value);
         end
      end else begin
         if (shadow_empty) begin
            r.status = ST_EMPTY;
         end else begin
            slot           = (w.operation == OP_POP_FRONT) ? shadow_front : shadow_rear;
            r.popped_value = $signed(shadow_ring[slot]);
            if (shadow_front == shadow_rear) begin
               // Removing the last entry sends both pointers home.
               shadow_front = 0;
               shadow_rear  = 0;
               shadow_empty = 1'b1;
            end else if (w.operation == OP_POP_FRONT) begin
               shadow_front = ring_next(shadow_front);
            end else begin
               shadow_rear = ring_prev(shadow_rear);
            end
         end
      end
      r.now_empty = shadow_empty;
      r.now_full  = shadow_full();
      return r;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
      shadow_front  = 0;
      shadow_rear   = 0;
      shadow_empty  = 1'b1;
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
   end

   // Compare each result word first, then predict for a newly taken word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (awaited_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result word %h", $realtime, rsp_word);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_word.popped_value !== want.popped_value ||
                   rsp_word.status       !== want.status ||
                   rsp_word.now_empty    !== want.now_empty ||
                   rsp_word.now_full     !== want.now_full) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: result mismatch, expected value %h status %0d",
                               " empty %b full %b, got value %h status %0d",
                               " empty %b full %b"},
                              $realtime, want.popped_value, want.status, want.now_empty,
                              want.now_full, rsp_word.popped_value, rsp_word.status,
                              rsp_word.now_empty, rsp_word.now_full);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            awaited_results.push_back(apply_deque_op(req_word));
      end
      pending_count = awaited_results.size();
   end

endmodule

// File: tb/tb_circular_deque_core.sv
`timescale 1ns / 100ps
// ============================================================================
// Circular deque core testbench
// Drives a directed run over empty, full and wrapping cases, then biased
// random fill, drain and even-mix runs with random gaps, while a checker compares
// every result word against its own prediction.
// ============================================================================
module tb_circular_deque_core;
   import cdq_pkg::*;

   localparam int RANDOM_WORDS = 1030;
   localparam int CYCLE_LIMIT  = 300000;

   typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} op_mix_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   cdq_req_type req_word;
   logic        rsp_strobe;
   cdq_rsp_type rsp_word;
   int          error_count;
   int          pending_count;
   int          cycle_count;

   circular_deque_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   cdq_result_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hang.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one request word and hold it until the core takes it.
   task automatic send_word(input logic [1:0] op, input logic signed [31:0] value);
      @(negedge clock);
      start    <= 1'b1;
      req_word <= '{operation: op, push_value: value};
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Leave the request channel idle, with junk on the word lines.
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start    <= 1'b0;
         req_word <= '{operation: 2'($urandom), push_value: $urandom};
      end
   endtask

   // Stop sending until every result has come back.
   task automatic wait_drained();
      idle_for(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Push values lean on the extremes now and then.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sd0;
         3:       return -32'sd1;
         4:       return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_op(input op_mix_type mix);
      logic push;
      case (mix)
         MIX_FILL:  push = ($urandom_range(0, 3) != 0);
         MIX_DRAIN: push = ($urandom_range(0, 3) == 0);
         default:   push = 1'($urandom_range(0, 1));
      endcase
      if (push) return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      op_mix_type mix;
      int         run_left;
      logic       no_gaps;

      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed run: refusals on empty, fill with wraps, refusals on full,
      // then drain through both pointer wraps until empty, with one more pop refused.
      send_word(OP_POP_FRONT,  32'sd0);
      send_word(OP_POP_REAR,   -32'sd1);
      send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_word(OP_POP_REAR,   32'sd0);
      send_word(OP_PUSH_REAR,  32'sh8000_0000);
      send_word(OP_PUSH_FRONT, 32'sd0);
      send_word(OP_PUSH_FRONT, -32'sd1);
      send_word(OP_PUSH_REAR,  32'sh5555_5555);
      send_word(OP_PUSH_REAR,  32'shAAAA_AAAA);
      send_word(OP_PUSH_FRONT, 32'sd1);
      send_word(OP_PUSH_FRONT, 32'sd2);
      send_word(OP_PUSH_REAR,  32'sd3);
      send_word(OP_PUSH_FRONT, 32'sd4);
      send_word(OP_PUSH_REAR,  32'sd5);
      send_word(OP_POP_FRONT,  32'sh7FFF_FFFF);
      send_word(OP_POP_REAR,   32'sd0);
      send_word(OP_POP_REAR,   32'sd0);
      send_word(OP_POP_REAR,   32'sd0);
      send_word(OP_POP_REAR,   32'sd0);
      send_word(OP_POP_FRONT,  32'sd0);
      send_word(OP_POP_FRONT,  32'sd0);
      send_word(OP_POP_FRONT,  32'sd0);
      send_word(OP_POP_REAR,   32'sd0);
      wait_drained();

      // Random runs alternate between filling, draining and an even mix.
      mix      = MIX_EVEN;
      run_left = 0;
      no_gaps  = 1'b0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 2))
               0:       mix = MIX_FILL;
               1:       mix = MIX_DRAIN;
               default: mix = MIX_EVEN;
            endcase
            run_left = $urandom_range(4, 40);
            no_gaps  = ($urandom_range(0, 2) == 0);
         end
         run_left--;
         send_word(pick_op(mix), pick_value());
         if (n == RANDOM_WORDS / 2 || $urandom_range(0, 99) == 0)
            wait_drained();
         else if (!no_gaps)
            idle_for(pick_gap());
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: circular_deque_core.f
+incdir+src
src/cdq_pkg.sv
src/cdq_cell.sv
src/circular_deque_core.sv
tb/cdq_result_checker.sv
tb/tb_circular_deque_core.sv
